### hw/rtl/emb_pkg.sv
// ----------------------------------------------------------------------------
// emb_pkg
// Shared types, constants and helper functions of the Even-Mansour block.
// ----------------------------------------------------------------------------
package emb_pkg;

	localparam int MAX_ROUNDS  = 8;
	localparam int BLOCK_WORDS = 16;
	localparam int WORD_BITS   = 64;
	localparam int ROT_BASE    = 41;

	localparam int IDX_W    = $clog2(BLOCK_WORDS);
	localparam int RND_W    = $clog2(MAX_ROUNDS + 1);
	localparam int RK_ROWS  = MAX_ROUNDS + 1;
	localparam int NUM_ROWS = RK_ROWS + 5;
	localparam int ROW_W    = $clog2(NUM_ROWS);
	localparam int ADDR_W   = ROW_W + IDX_W;
	localparam int MEM_DEPTH = NUM_ROWS * BLOCK_WORDS;

	localparam logic [ROW_W-1:0] ROW_BLK0 = ROW_W'(RK_ROWS);
	localparam logic [ROW_W-1:0] ROW_BLK1 = ROW_W'(RK_ROWS + 1);
	localparam logic [ROW_W-1:0] ROW_MKEY = ROW_W'(RK_ROWS + 2);
	localparam logic [ROW_W-1:0] ROW_WRK0 = ROW_W'(RK_ROWS + 3);
	localparam logic [ROW_W-1:0] ROW_WRK1 = ROW_W'(RK_ROWS + 4);

	localparam logic REQ_KEY   = 1'b0;
	localparam logic REQ_PLAIN = 1'b1;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic              act;
		logic              re_a;
		logic [ADDR_W-1:0] addr_a;
		logic              re_b;
		logic [ADDR_W-1:0] addr_b;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		word_t             wdata;
	} mem_req_t;

	typedef struct packed {
		logic             start;
		logic             mixed;
		logic [ROW_W-1:0] src;
		logic [ROW_W-1:0] dst;
		word_t            k;
	} perm_cmd_t;

	typedef struct packed {
		logic  done;
		word_t k;
	} perm_sts_t;

	function automatic word_t rotl(input word_t x, input logic [5:0] n);
		logic [2*WORD_BITS-1:0] d;
		d = {x, x} << n;
		return d[2*WORD_BITS-1:WORD_BITS];
	endfunction

	function automatic word_t sext32(input word_t v);
		return {{32{v[31]}}, v[31:0]};
	endfunction

	function automatic logic [IDX_W-1:0] shuf_src(input logic [IDX_W-1:0] i);
		logic [IDX_W-1:0] s;
		case (i)
			4'd0:    s = 4'd11;
			4'd1:    s = 4'd5;
			4'd2:    s = 4'd4;
			4'd3:    s = 4'd15;
			4'd4:    s = 4'd12;
			4'd5:    s = 4'd6;
			4'd6:    s = 4'd9;
			4'd7:    s = 4'd0;
			4'd8:    s = 4'd13;
			4'd9:    s = 4'd3;
			4'd10:   s = 4'd14;
			4'd11:   s = 4'd8;
			4'd12:   s = 4'd1;
			4'd13:   s = 4'd10;
			4'd14:   s = 4'd2;
			default: s = 4'd7;
		endcase
		return s;
	endfunction

endpackage

### hw/rtl/emb_ram.sv
// ----------------------------------------------------------------------------
// emb_ram
// Synchronous RAM, one write port, two read ports with registered data.
// ----------------------------------------------------------------------------
module emb_ram #(
	parameter int DEPTH  = 224,
	parameter int WIDTH  = 64,
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re_a,
	input  logic [ADDR_W-1:0] raddr_a,
	output logic [WIDTH-1:0]  rdata_a,
	input  logic              re_b,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [WIDTH-1:0]  rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re_a)
			rdata_a <= mem_q[raddr_a];
		if (re_b)
			rdata_b <= mem_q[raddr_b];
	end

endmodule

### hw/rtl/emb_perm.sv
// ----------------------------------------------------------------------------
// emb_perm
// Keyed permutation engine: shuffled read, chained add-rotate-xor pairs.
// ----------------------------------------------------------------------------
module emb_perm (
	input  logic              clk,
	input  logic              arst_n,
	input  emb_pkg::perm_cmd_t cmd,
	input  emb_pkg::word_t    rd_a,
	output emb_pkg::perm_sts_t sts,
	output emb_pkg::mem_req_t req
);
	import emb_pkg::*;

	typedef enum logic [4:0] {
		P_IDLE = 5'b00001,
		P_LD   = 5'b00010,
		P_A    = 5'b00100,
		P_B    = 5'b01000,
		P_W    = 5'b10000
	} perm_state_t;

	perm_state_t      state_q;
	logic [IDX_W-1:0] j_q;
	logic             fin_q;
	logic             mixed_q;
	logic [ROW_W-1:0] src_q;
	logic [ROW_W-1:0] dst_q;
	word_t            k_q;
	word_t            carry_q;
	word_t            s15_q;
	word_t            l_s1;
	word_t            r_s1;
	word_t            k_s1;

	logic [IDX_W-1:0] li;
	word_t            l_in;
	word_t            k1;
	word_t            rn;
	word_t            ln;

	always_comb begin
		li   = fin_q ? IDX_W'(BLOCK_WORDS - 1) : j_q;
		l_in = fin_q ? s15_q : rd_a;
		k1   = mixed_q ? k_q : (k_q ^ carry_q);
		rn   = rotl(carry_q + k1 + WORD_BITS'(li), 6'(ROT_BASE));
		ln   = (l_s1 + {32'd0, r_s1[63:32]}) ^ rotl(r_s1, 6'(li) ^ 6'(ROT_BASE));
	end

	always_comb begin
		req = '0;
		case (state_q)
			P_IDLE: begin
				if (cmd.start) begin
					req.act    = 1'b1;
					req.re_a   = 1'b1;
					req.addr_a = {cmd.src, shuf_src(IDX_W'(BLOCK_WORDS - 1))};
				end
			end
			P_LD: begin
				req.act    = 1'b1;
				req.re_a   = 1'b1;
				req.addr_a = {src_q, shuf_src(IDX_W'(BLOCK_WORDS - 2))};
			end
			P_A: begin
				req.act = 1'b1;
			end
			P_B: begin
				req.act = 1'b1;
				if (!fin_q) begin
					if (j_q != IDX_W'(BLOCK_WORDS - 2)) begin
						req.we    = 1'b1;
						req.waddr = {dst_q, j_q + IDX_W'(1)};
						req.wdata = r_s1;
					end
					if (j_q != '0) begin
						req.re_a   = 1'b1;
						req.addr_a = {src_q, shuf_src(j_q - IDX_W'(1))};
					end
				end else begin
					req.we    = 1'b1;
					req.waddr = {dst_q, IDX_W'(0)};
					req.wdata = r_s1;
				end
			end
			P_W: begin
				req.act   = 1'b1;
				req.we    = 1'b1;
				req.waddr = {dst_q, IDX_W'(BLOCK_WORDS - 1)};
				req.wdata = carry_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			fin_q   <= 1'b0;
		end else begin
			case (state_q)
				P_IDLE: begin
					if (cmd.start)
						state_q <= P_LD;
				end
				P_LD: begin
					fin_q   <= 1'b0;
					state_q <= P_A;
				end
				P_A: state_q <= P_B;
				P_B: begin
					if (fin_q)
						state_q <= P_W;
					else begin
						if (j_q == '0)
							fin_q <= 1'b1;
						state_q <= P_A;
					end
				end
				P_W: begin
					fin_q   <= 1'b0;
					state_q <= P_IDLE;
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			P_IDLE: begin
				if (cmd.start) begin
					mixed_q <= cmd.mixed;
					src_q   <= cmd.src;
					dst_q   <= cmd.dst;
					k_q     <= cmd.k;
				end
			end
			P_LD: begin
				carry_q <= rd_a;
				j_q     <= IDX_W'(BLOCK_WORDS - 2);
			end
			P_A: begin
				l_s1 <= l_in;
				r_s1 <= rn;
				k_s1 <= k1 ^ rn ^ l_in;
			end
			P_B: begin
				k_q     <= k_s1 ^ ln;
				carry_q <= ln;
				if (!fin_q) begin
					if (j_q == IDX_W'(BLOCK_WORDS - 2))
						s15_q <= r_s1;
					if (j_q != '0)
						j_q <= j_q - IDX_W'(1);
				end
			end
			default: ;
		endcase
	end

	assign sts.done = (state_q == P_W);
	assign sts.k    = k_q;

	a_w_returns: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == P_W |=> state_q == P_IDLE)
		else $error("permute write-back did not return to idle");
	a_w_final: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == P_W |-> fin_q)
		else $error("permute finished before the closing pair");

endmodule

### hw/rtl/emb_ctrl.sv
// ----------------------------------------------------------------------------
// emb_ctrl
// Sequencer: request intake, key schedule, round passes and result output.
// ----------------------------------------------------------------------------
module emb_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     req_type,
	input  logic [emb_pkg::IDX_W-1:0] word_index,
	input  emb_pkg::word_t           word,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [emb_pkg::IDX_W-1:0] out_index,
	output emb_pkg::word_t           out_word,
	output logic                     last,
	output logic                     key_missing,
	input  logic [3:0]               round_count,
	input  emb_pkg::word_t           rd_a,
	input  emb_pkg::word_t           rd_b,
	input  emb_pkg::perm_sts_t       perm_sts,
	output emb_pkg::perm_cmd_t       perm_cmd,
	output emb_pkg::mem_req_t        req
);
	import emb_pkg::*;

	typedef enum logic [8:0] {
		C_IDLE = 9'b000000001,
		C_KX   = 9'b000000010,
		C_SPN  = 9'b000000100,
		C_SPM  = 9'b000001000,
		C_EX   = 9'b000010000,
		C_EP   = 9'b000100000,
		C_ORD  = 9'b001000000,
		C_OLD  = 9'b010000000,
		C_OWT  = 9'b100000000
	} ctrl_state_t;

	ctrl_state_t      state_q;
	logic [IDX_W:0]   x_q;
	word_t            acc_q;
	word_t            kx_q;
	logic [RND_W-1:0] rnd_q;
	logic [RND_W-1:0] nrnd_q;
	logic [RND_W-1:0] sched_q;
	logic             key_ready_q;
	logic             blk_q;
	logic [ROW_W-1:0] wcur_q;
	logic             started_q;
	logic [IDX_W-1:0] oi_q;

	logic             accept;
	logic [RND_W-1:0] n_sat;
	logic [ROW_W-1:0] blk_row;
	logic [ROW_W-1:0] blk_alt;
	logic [ROW_W-1:0] wrk_alt;
	logic [ROW_W-1:0] rk_row;
	logic [IDX_W:0]   x_m1;
	word_t            xv;
	word_t            acc_next;
	logic             pass_end;

	assign in_ready = (state_q == C_IDLE);
	assign accept   = in_valid && in_ready;
	assign blk_row  = blk_q ? ROW_BLK1 : ROW_BLK0;
	assign blk_alt  = blk_q ? ROW_BLK0 : ROW_BLK1;
	assign wrk_alt  = (wcur_q == ROW_WRK0) ? ROW_WRK1 : ROW_WRK0;
	assign rk_row   = ROW_W'(rnd_q);
	assign x_m1     = x_q - (IDX_W+1)'(1);
	assign xv       = (state_q == C_EX) ? (rd_a ^ rd_b) : rd_a;
	assign acc_next = acc_q ^ xv;
	assign pass_end = (x_q == (IDX_W+1)'(BLOCK_WORDS));

	always_comb begin
		if (round_count == 4'd0)
			n_sat = RND_W'(1);
		else if (RND_W'(round_count) > RND_W'(MAX_ROUNDS) || 32'(round_count) > MAX_ROUNDS)
			n_sat = RND_W'(MAX_ROUNDS);
		else
			n_sat = RND_W'(round_count);
	end

	always_comb begin
		perm_cmd       = '0;
		perm_cmd.start = ((state_q == C_SPN) || (state_q == C_SPM) || (state_q == C_EP))
			&& !started_q;
		perm_cmd.k     = kx_q;
		case (state_q)
			C_SPN: begin
				perm_cmd.src = wcur_q;
				perm_cmd.dst = wrk_alt;
			end
			C_SPM: begin
				perm_cmd.mixed = 1'b1;
				perm_cmd.src   = wcur_q;
				perm_cmd.dst   = rk_row;
			end
			C_EP: begin
				perm_cmd.src = blk_row;
				perm_cmd.dst = blk_alt;
			end
			default: ;
		endcase
	end

	always_comb begin
		req = '0;
		case (state_q)
			C_IDLE: begin
				if (accept) begin
					req.we    = 1'b1;
					req.waddr = {(req_type == REQ_PLAIN) ? blk_row : ROW_MKEY, word_index};
					req.wdata = word;
				end
			end
			C_KX, C_EX: begin
				if (!pass_end) begin
					req.re_a   = 1'b1;
					req.addr_a = {(state_q == C_EX) ? blk_row : ROW_MKEY, x_q[IDX_W-1:0]};
					req.re_b   = (state_q == C_EX);
					req.addr_b = {rk_row, x_q[IDX_W-1:0]};
				end
				if (state_q == C_EX && x_q != '0) begin
					req.we    = 1'b1;
					req.waddr = {blk_row, x_m1[IDX_W-1:0]};
					req.wdata = xv;
				end
			end
			C_ORD: begin
				req.re_a   = 1'b1;
				req.addr_a = {blk_row, oi_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_IDLE;
			key_ready_q <= 1'b0;
			sched_q     <= RND_W'(1);
			blk_q       <= 1'b0;
			started_q   <= 1'b0;
			out_valid   <= 1'b0;
			x_q         <= '0;
			rnd_q       <= '0;
			oi_q        <= '0;
		end else begin
			if (perm_cmd.start)
				started_q <= 1'b1;
			case (state_q)
				C_IDLE: begin
					if (accept && word_index == IDX_W'(BLOCK_WORDS - 1)) begin
						x_q   <= '0;
						rnd_q <= '0;
						oi_q  <= '0;
						if (req_type == REQ_KEY)
							state_q <= C_KX;
						else if (key_ready_q)
							state_q <= C_EX;
						else
							state_q <= C_ORD;
					end
				end
				C_KX: begin
					x_q <= x_q + (IDX_W+1)'(1);
					if (pass_end)
						state_q <= C_SPN;
				end
				C_SPN: begin
					if (perm_sts.done) begin
						started_q <= 1'b0;
						state_q   <= C_SPM;
					end
				end
				C_SPM: begin
					if (perm_sts.done) begin
						started_q <= 1'b0;
						if (rnd_q == nrnd_q) begin
							key_ready_q <= 1'b1;
							sched_q     <= nrnd_q;
							state_q     <= C_IDLE;
						end else begin
							rnd_q   <= rnd_q + RND_W'(1);
							state_q <= C_SPN;
						end
					end
				end
				C_EX: begin
					x_q <= x_q + (IDX_W+1)'(1);
					if (pass_end)
						state_q <= (rnd_q == sched_q) ? C_ORD : C_EP;
				end
				C_EP: begin
					if (perm_sts.done) begin
						started_q <= 1'b0;
						blk_q     <= ~blk_q;
						rnd_q     <= rnd_q + RND_W'(1);
						x_q       <= '0;
						state_q   <= C_EX;
					end
				end
				C_ORD: state_q <= C_OLD;
				C_OLD: begin
					out_valid <= 1'b1;
					state_q   <= C_OWT;
				end
				C_OWT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						if (oi_q == IDX_W'(BLOCK_WORDS - 1))
							state_q <= C_IDLE;
						else begin
							oi_q    <= oi_q + IDX_W'(1);
							state_q <= C_ORD;
						end
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				acc_q <= '0;
				if (accept)
					nrnd_q <= n_sat;
			end
			C_KX: begin
				if (x_q != '0)
					acc_q <= acc_next;
				if (pass_end) begin
					kx_q   <= acc_next;
					wcur_q <= ROW_MKEY;
				end
			end
			C_SPN: begin
				if (perm_sts.done) begin
					kx_q   <= sext32(perm_sts.k);
					wcur_q <= wrk_alt;
				end
			end
			C_EX: begin
				if (x_q != '0)
					acc_q <= acc_next;
				if (pass_end)
					kx_q <= acc_next;
			end
			C_EP: acc_q <= '0;
			C_OLD: begin
				out_word    <= rd_a;
				out_index   <= oi_q;
				last        <= (oi_q == IDX_W'(BLOCK_WORDS - 1));
				key_missing <= ~key_ready_q;
			end
			default: ;
		endcase
	end

	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == C_OWT)
		else $error("result shown outside output wait");
	a_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("intake open while a result is pending");
	a_sched_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == C_SPM && perm_sts.done && rnd_q == nrnd_q) |=> key_ready_q)
		else $error("schedule finished without marking key ready");

endmodule

### hw/rtl/even_mansour_block_encrypt.sv
// ----------------------------------------------------------------------------
// even_mansour_block_encrypt
// Iterated Even-Mansour encryption of 16-word blocks with a stored schedule.
// ----------------------------------------------------------------------------
// Intake: words are taken only while idle (in_ready high); a key word at index 15
//   starts a key schedule, a plaintext word at index 15 starts the rounds if a
//   key is ready (else the block is sent back with key_missing set), then each
//   ciphertext word is shown in turn and held until out_ready takes it.
// One request at a time: intake stays closed until the schedule or output ends.
// Reset: round_count returns to 8, no key schedule; memory contents are kept.
// ----------------------------------------------------------------------------
module even_mansour_block_encrypt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [3:0]               cfg_round_count,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     req_type,
	input  logic [emb_pkg::IDX_W-1:0] word_index,
	input  emb_pkg::word_t           word,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [emb_pkg::IDX_W-1:0] out_index,
	output emb_pkg::word_t           out_word,
	output logic                     last,
	output logic                     key_missing
);
	import emb_pkg::*;

	logic [3:0] round_count_q;
	perm_cmd_t  perm_cmd;
	perm_sts_t  perm_sts;
	mem_req_t   ctrl_req;
	mem_req_t   perm_req;
	mem_req_t   mem_req;
	word_t      rd_a;
	word_t      rd_b;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			round_count_q <= 4'd8;
		else if (cfg_valid && cfg_ready)
			round_count_q <= cfg_round_count;
	end

	assign mem_req = perm_req.act ? perm_req : ctrl_req;

	emb_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.word_index  (word_index),
		.word        (word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_index   (out_index),
		.out_word    (out_word),
		.last        (last),
		.key_missing (key_missing),
		.round_count (round_count_q),
		.rd_a        (rd_a),
		.rd_b        (rd_b),
		.perm_sts    (perm_sts),
		.perm_cmd    (perm_cmd),
		.req         (ctrl_req)
	);

	emb_perm u_perm (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (perm_cmd),
		.rd_a   (rd_a),
		.sts    (perm_sts),
		.req    (perm_req)
	);

	emb_ram #(
		.DEPTH  (MEM_DEPTH),
		.WIDTH  (WORD_BITS),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.we      (mem_req.we),
		.waddr   (mem_req.waddr),
		.wdata   (mem_req.wdata),
		.re_a    (mem_req.re_a),
		.raddr_a (mem_req.addr_a),
		.rdata_a (rd_a),
		.re_b    (mem_req.re_b),
		.raddr_b (mem_req.addr_b),
		.rdata_b (rd_b)
	);

endmodule
